// File: hw/rtl/dtqf_pkg.sv
// shared types and constants for the drop-tail queue with congestion feedback
`timescale 1ns / 1ps

package dtqf_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;

  localparam int unsigned CFG_WIDTH = 9;
  localparam logic [CFG_WIDTH-1:0] BUFFER_SIZE_RESET = 9'd256;
  localparam logic [CFG_WIDTH-1:0] FEEDBACK_THR_RESET = 9'd217;

  typedef enum logic {
    CFG_BUFFER_SIZE  = 1'b0,
    CFG_FEEDBACK_THR = 1'b1
  } cfg_index_e;

  typedef enum logic {
    REQ_ARRIVAL = 1'b0,
    REQ_TICK    = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] packet_tag;
    logic [15:0] packet_duration;
  } req_t;

  typedef struct packed {
    logic        sent_valid;
    logic [15:0] sent_tag;
    logic        sent_is_feedback;
    logic        was_dropped;
    logic [31:0] drop_total;
    logic [8:0]  occupancy;
    logic        server_busy;
  } rsp_t;

  // one ring entry
  typedef struct packed {
    logic        is_feedback;
    logic [15:0] duration;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] buffer_size;
    logic [CFG_WIDTH-1:0] feedback_threshold;
  } cfg_t;

endpackage

// File: hw/rtl/dtqf_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dtqf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/dtqf_cfg.sv
// configuration registers: buffer size and feedback threshold
`timescale 1ns / 1ps

module dtqf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [dtqf_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  output dtqf_pkg::cfg_t                  cfg_o
);

  import dtqf_pkg::*;

  logic [CFG_WIDTH-1:0] buffer_size_q, buffer_size_d;
  logic [CFG_WIDTH-1:0] threshold_q, threshold_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    buffer_size_d = buffer_size_q;
    threshold_d   = threshold_q;
    if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_BUFFER_SIZE:  buffer_size_d = cfg_data_i;
        CFG_FEEDBACK_THR: threshold_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= BUFFER_SIZE_RESET;
      threshold_q   <= FEEDBACK_THR_RESET;
    end else begin
      buffer_size_q <= buffer_size_d;
      threshold_q   <= threshold_d;
    end
  end

  assign cfg_o.buffer_size        = buffer_size_q;
  assign cfg_o.feedback_threshold = threshold_q;

endmodule

// File: hw/rtl/drop_tail_queue_with_feedback_top.sv
// Drop-tail queue with congestion feedback: ring in one ram, read-modify-write sequencer.
// A drop, plain arrival or tick without a send finishes in EXEC; an arrival with a
// feedback entry adds TAIL for the packet write, and a tick that sends adds POP.
// One item at a time: busy stays high until the result is issued. TAIL exists for
// the single write port, POP for the registered ram read.
// Async active-low reset clears pointers, count, server state and drop counter;
// the ring ram is not cleared (entries are read only after being written).
`timescale 1ns / 1ps

module drop_tail_queue_with_feedback_top #(
  parameter int unsigned QueueDepth = dtqf_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  dtqf_pkg::req_t                  req_i,
  output logic                            result_valid_o,
  output dtqf_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [dtqf_pkg::CFG_WIDTH-1:0]  cfg_data_i
);

  import dtqf_pkg::*;

  localparam int unsigned Slots = QueueDepth + 1;
  localparam int unsigned AW    = $clog2(Slots);
  localparam int unsigned CW    = $clog2(Slots + 1);
  localparam int unsigned CMPW  = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_TAIL = 4'b0100,
    ST_POP  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          srv_busy_q, srv_busy_d;
  logic [15:0]   countdown_q, countdown_d;
  logic [31:0]   drop_q, drop_d;
  req_t          req_q;
  logic          done_q;
  rsp_t          rsp_q;

  cfg_t          cfg;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata, ram_rdata;
  logic [$bits(entry_t)-1:0] ram_rdata_raw;

  logic            emit;
  logic            sent, sent_fb, dropped;
  logic [15:0]     sent_tag;
  logic [CMPW-1:0] count_ext, limit, thr_ext, bsize_ext;
  logic [CW:0]     tail_sum;
  logic [AW-1:0]   tail_addr, head_dec, head_inc;
  logic [15:0]     countdown_dec;
  logic [CMPW-1:0] occ_ext;
  entry_t          packet_entry, feedback_entry;

  dtqf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dtqf_ram #(
    .Width ($bits(entry_t)),
    .Depth (Slots)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // buffer sizes beyond QueueDepth act as QueueDepth
  assign bsize_ext = CMPW'(cfg.buffer_size);
  assign limit     = (bsize_ext > CMPW'(QueueDepth)) ? CMPW'(QueueDepth) : bsize_ext;
  assign thr_ext   = CMPW'(cfg.feedback_threshold);
  assign count_ext = CMPW'(count_q);

  // tail slot: head + count, wrapped once
  assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
  assign tail_addr = (tail_sum >= (CW+1)'(Slots)) ? AW'(tail_sum - (CW+1)'(Slots))
                                                  : AW'(tail_sum);
  assign head_dec  = (head_q == '0) ? AW'(Slots - 1) : head_q - 1'b1;
  assign head_inc  = (head_q == AW'(Slots - 1)) ? '0 : head_q + 1'b1;
  assign countdown_dec = (countdown_q != '0) ? countdown_q - 16'd1 : 16'd0;

  always_comb begin
    packet_entry.is_feedback   = 1'b0;
    packet_entry.duration      = req_q.packet_duration;
    packet_entry.tag           = req_q.packet_tag;
    feedback_entry.is_feedback = 1'b1;
    feedback_entry.duration    = 16'd0;
    feedback_entry.tag         = 16'd0;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    srv_busy_d  = srv_busy_q;
    countdown_d = countdown_q;
    drop_d      = drop_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tail_addr;
    ram_wdata   = packet_entry;
    emit        = 1'b0;
    sent        = 1'b0;
    sent_fb     = 1'b0;
    sent_tag    = 16'd0;
    dropped     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_type_e'(req_q.req_type) == REQ_ARRIVAL) begin
          if (count_ext >= limit) begin
            dropped = 1'b1;
            if (drop_q != 32'hFFFF_FFFF) begin
              drop_d = drop_q + 32'd1;
            end
            emit    = 1'b1;
            state_d = ST_IDLE;
          end else if (count_ext >= thr_ext) begin
            // feedback goes in front of the head, packet follows next cycle
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            ram_wdata = feedback_entry;
            head_d    = head_dec;
            count_d   = count_q + 1'b1;
            state_d   = ST_TAIL;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
            if (!srv_busy_q) begin
              srv_busy_d  = 1'b1;
              countdown_d = 16'd0;
            end
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          if (srv_busy_q) begin
            countdown_d = countdown_dec;
            if (countdown_dec == 16'd0) begin
              if (count_q != '0) begin
                ram_re  = 1'b1;
                state_d = ST_POP;
              end else begin
                srv_busy_d = 1'b0;
                emit       = 1'b1;
                state_d    = ST_IDLE;
              end
            end else begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        ram_we  = 1'b1;
        count_d = count_q + 1'b1;
        if (!srv_busy_q) begin
          srv_busy_d  = 1'b1;
          countdown_d = 16'd0;
        end
        emit    = 1'b1;
        state_d = ST_IDLE;
      end
      ST_POP: begin
        head_d      = head_inc;
        count_d     = count_q - 1'b1;
        countdown_d = ram_rdata.duration;
        sent        = 1'b1;
        sent_fb     = ram_rdata.is_feedback;
        sent_tag    = ram_rdata.is_feedback ? 16'd0 : ram_rdata.tag;
        emit        = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign occ_ext = CMPW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      srv_busy_q  <= 1'b0;
      countdown_q <= 16'd0;
      drop_q      <= 32'd0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      srv_busy_q  <= srv_busy_d;
      countdown_q <= countdown_d;
      drop_q      <= drop_d;
      done_q      <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      req_q <= req_i;
    end
    if (emit) begin
      rsp_q.sent_valid       <= sent;
      rsp_q.sent_tag         <= sent_tag;
      rsp_q.sent_is_feedback <= sent_fb;
      rsp_q.was_dropped      <= dropped;
      rsp_q.drop_total       <= drop_d;
      rsp_q.occupancy        <= occ_ext[8:0];
      rsp_q.server_busy      <= srv_busy_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = done_q;
  assign rsp_o          = rsp_q;

endmodule

// File: hw/rtl/dtqf_checker.sv
// port-level checks for the drop-tail queue top level, attached by bind
`timescale 1ns / 1ps

module dtqf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input dtqf_pkg::req_t  req_i,
  input logic            result_valid_o,
  input dtqf_pkg::rsp_t  rsp_o
);

  import dtqf_pkg::*;

  // an accepted item raises busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // no result in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !result_valid_o)
    else $error("result strobe too early after accept");

  // a send and a drop never come from the same item; feedback carries tag zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(rsp_o.sent_valid && rsp_o.was_dropped) &&
                       (!rsp_o.sent_is_feedback || (rsp_o.sent_valid &&
                                                    rsp_o.sent_tag == 16'd0)))
    else $error("inconsistent send or drop flags");

  // a sent item starts or continues a service period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.sent_valid |-> rsp_o.server_busy)
    else $error("item sent while server idle");

  // a drop leaves a nonzero running total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.was_dropped |-> rsp_o.drop_total != 32'd0)
    else $error("drop with zero drop total");

endmodule

bind drop_tail_queue_with_feedback_top dtqf_checker u_dtqf_checker (.*);

// File: dv/drop_tail_queue_with_feedback_top_tb.sv
// self-checking testbench for the drop-tail queue with congestion feedback
`timescale 1ns / 1ps

module drop_tail_queue_with_feedback_top_tb;
  import dtqf_pkg::*;

  localparam int unsigned RING_SLOTS = QUEUE_DEPTH + 1;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_WAIT_LIMIT = 1000;
  localparam int unsigned MAX_PRINTS = 50;
  localparam real TIMEOUT_NS = 2_000_000.0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic result_valid_o;
  rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = CFG_BUFFER_SIZE;
  logic [CFG_WIDTH-1:0] cfg_data_i = '0;

  drop_tail_queue_with_feedback_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the queue and server
  entry_t               shadow_ring [RING_SLOTS];
  int unsigned          shadow_head = 0;
  int unsigned          shadow_count = 0;
  bit                   shadow_busy = 1'b0;
  logic [15:0]          shadow_countdown = '0;
  logic [31:0]          shadow_drops = '0;
  logic [CFG_WIDTH-1:0] shadow_size = BUFFER_SIZE_RESET;
  logic [CFG_WIDTH-1:0] shadow_thr = FEEDBACK_THR_RESET;

  req_t req_backlog [$];
  rsp_t awaited_rsp [$];

  int unsigned mismatch_count = 0;
  int unsigned items_accepted = 0;
  int unsigned sends_seen = 0;
  int unsigned feedback_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned peak_occupancy = 0;
  int unsigned gap_left = 0;
  bit hold_for_drain = 1'b0;
  bit quiet = 1'b0;

  function automatic rsp_t queue_step(req_t r);
    rsp_t        o;
    int unsigned limit;
    entry_t      head_entry;
    o = '0;
    if (r.req_type == REQ_ARRIVAL) begin
      limit = (shadow_size > QUEUE_DEPTH) ? QUEUE_DEPTH : shadow_size;
      if (shadow_count >= limit) begin
        o.was_dropped = 1'b1;
        if (shadow_drops != '1) shadow_drops++;
      end else begin
        // feedback goes in front of the head
        if (shadow_count >= shadow_thr) begin
          shadow_head = (shadow_head == 0) ? RING_SLOTS - 1 : shadow_head - 1;
          shadow_ring[shadow_head] = entry_t'{is_feedback: 1'b1, duration: '0, tag: '0};
          shadow_count++;
        end
        shadow_ring[(shadow_head + shadow_count) % RING_SLOTS] =
          entry_t'{is_feedback: 1'b0, duration: r.packet_duration, tag: r.packet_tag};
        shadow_count++;
        if (!shadow_busy) begin
          shadow_busy = 1'b1;
          shadow_countdown = '0;
        end
      end
    end else if (shadow_busy) begin
      if (shadow_countdown != 0) shadow_countdown--;
      if (shadow_countdown == 0) begin
        if (shadow_count != 0) begin
          head_entry = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % RING_SLOTS;
          shadow_count--;
          o.sent_valid = 1'b1;
          o.sent_is_feedback = head_entry.is_feedback;
          o.sent_tag = head_entry.is_feedback ? 16'h0 : head_entry.tag;
          shadow_countdown = head_entry.duration;
        end else begin
          shadow_busy = 1'b0;
        end
      end
    end
    o.drop_total = shadow_drops;
    o.occupancy = shadow_count[8:0];
    o.server_busy = shadow_busy;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // driver: one item at a time from the backlog
  always @(posedge clk_i) begin : drive_items
    logic nxt_start;
    nxt_start = start;
    if (rst_ni) begin
      if (start && !busy) begin
        awaited_rsp.push_back(queue_step(req_i));
        items_accepted++;
        nxt_start = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
        if (!quiet && $urandom_range(0, 39) == 0) hold_for_drain = 1'b1;
      end
      if (!nxt_start) begin
        if (awaited_rsp.size() == 0) hold_for_drain = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!hold_for_drain && req_backlog.size() != 0) begin
          req_i <= req_backlog.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor: every strobe is checked against the oldest prediction
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("result strobe with nothing pending", 1, 0);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_o.sent_valid !== want.sent_valid)
          report_mismatch("sent_valid", rsp_o.sent_valid, want.sent_valid);
        if (rsp_o.sent_tag !== want.sent_tag)
          report_mismatch("sent_tag", rsp_o.sent_tag, want.sent_tag);
        if (rsp_o.sent_is_feedback !== want.sent_is_feedback)
          report_mismatch("sent_is_feedback", rsp_o.sent_is_feedback, want.sent_is_feedback);
        if (rsp_o.was_dropped !== want.was_dropped)
          report_mismatch("was_dropped", rsp_o.was_dropped, want.was_dropped);
        if (rsp_o.drop_total !== want.drop_total)
          report_mismatch("drop_total", rsp_o.drop_total, want.drop_total);
        if (rsp_o.occupancy !== want.occupancy)
          report_mismatch("occupancy", rsp_o.occupancy, want.occupancy);
        if (rsp_o.server_busy !== want.server_busy)
          report_mismatch("server_busy", rsp_o.server_busy, want.server_busy);
        if (want.sent_valid) sends_seen++;
        if (want.sent_is_feedback) feedback_seen++;
        if (want.was_dropped) drops_seen++;
        if (want.occupancy > peak_occupancy) peak_occupancy = want.occupancy;
      end
    end
  end

  task automatic push_item(req_type_e kind, logic [15:0] tag, logic [15:0] dur);
    req_t r;
    r.req_type = kind;
    r.packet_tag = tag;
    r.packet_duration = dur;
    req_backlog.push_back(r);
  endtask

  // wait until no item is queued, presented or in flight
  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || start || awaited_rsp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CFG_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_BUFFER_SIZE) shadow_size = val;
    else shadow_thr = val;
  endtask

  task automatic set_limits(logic [CFG_WIDTH-1:0] size, logic [CFG_WIDTH-1:0] thr);
    wait_drained();
    write_reg(CFG_BUFFER_SIZE, size);
    write_reg(CFG_FEEDBACK_THR, thr);
    @(negedge clk_i);
  endtask

  // wide_dur spreads durations over all 16 bits, meant for phases where arrivals drop
  task automatic random_phase(logic [CFG_WIDTH-1:0] size, logic [CFG_WIDTH-1:0] thr,
                              int unsigned n, int unsigned arrival_pct,
                              int unsigned dur_max, bit wide_dur);
    set_limits(size, thr);
    repeat (n) begin
      if ($urandom_range(0, 99) < arrival_pct)
        push_item(REQ_ARRIVAL, 16'($urandom),
                  wide_dur ? 16'($urandom) : 16'($urandom_range(0, dur_max)));
      else
        push_item(REQ_TICK, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned guard;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limits: tick while idle, zero duration, tag extremes, server idling
    push_item(REQ_TICK, 16'h0, 16'h0);
    push_item(REQ_ARRIVAL, 16'h0000, 16'h0000);
    push_item(REQ_ARRIVAL, 16'hffff, 16'h0001);
    repeat (4) push_item(REQ_TICK, 16'hffff, 16'hffff);

    // buffer size zero drops everything
    set_limits(9'd0, 9'd0);
    push_item(REQ_ARRIVAL, 16'h1234, 16'h0005);
    push_item(REQ_ARRIVAL, 16'hedcb, 16'hfffe);
    push_item(REQ_TICK, 16'h0, 16'h0);

    // threshold zero on an empty queue, then a full queue
    set_limits(9'd2, 9'd0);
    push_item(REQ_ARRIVAL, 16'h00a5, 16'h0001);
    push_item(REQ_ARRIVAL, 16'h005a, 16'h0001);
    repeat (3) push_item(REQ_TICK, 16'h0, 16'h0);

    // feedback jumps ahead of a waiting packet
    set_limits(9'd3, 9'd1);
    push_item(REQ_ARRIVAL, 16'h0101, 16'h0000);
    push_item(REQ_ARRIVAL, 16'h0202, 16'h0000);
    repeat (4) push_item(REQ_TICK, 16'h0, 16'h0);

    random_phase(9'd8, 9'd5, 100, 60, 3, 1'b0);
    random_phase(9'd0, 9'd0, 40, 80, 0, 1'b1);
    // size above capacity acts as full depth: fill to the top, feedback, drops
    random_phase(9'd300, 9'd217, 300, 95, 2, 1'b0);
    random_phase(9'd511, 9'd511, 120, 30, 1, 1'b0);
    random_phase(9'd1, 9'd1, 60, 50, 2, 1'b0);
    random_phase(9'd5, 9'd9, 60, 60, 2, 1'b0);
    random_phase(9'd4, 9'd0, 80, 50, 3, 1'b0);
    wait_drained();
    quiet = 1'b1;
    random_phase(9'd16, 9'd12, 100, 55, 3, 1'b0);

    // empty the queue, then serve the longest duration
    wait_drained();
    while (shadow_count != 0 || shadow_busy) begin
      push_item(REQ_TICK, 16'h0, 16'h0);
      wait_drained();
    end
    set_limits(9'd256, 9'd256);
    push_item(REQ_ARRIVAL, 16'hffff, 16'hffff);
    push_item(REQ_ARRIVAL, 16'h8001, 16'hffff);
    repeat (3) push_item(REQ_TICK, 16'h0, 16'h0);

    do @(posedge clk_i);
    while (req_backlog.size() != 0 || start);
    guard = 0;
    while (awaited_rsp.size() != 0 && guard < END_WAIT_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_rsp.size() != 0)
      report_mismatch("results never arrived", 0, awaited_rsp.size());

    $display("ran %0d items over 13 limit settings: %0d sends, %0d of them feedback",
             items_accepted, sends_seen, feedback_seen);
    $display("%0d drops, peak occupancy %0d, %0d mismatches",
             drops_seen, peak_occupancy, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS drop_tail_queue_with_feedback_top");
    end else begin
      $display("FAIL drop_tail_queue_with_feedback_top");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d results pending", awaited_rsp.size());
    $display("FAIL drop_tail_queue_with_feedback_top");
    $finish;
  end

endmodule
